// ===== sv/pthc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pthc_pkg
// types, constants and register indexes of the compensation unit
// ---------------------------------------------------------------------------
package pthc_pkg;

   localparam logic [23:0] SKIP_TP = 24'h800000;
   localparam logic [15:0] SKIP_H  = 16'h8000;
   localparam logic [31:0] HUM_MAX = 32'd419430400;

   localparam logic [2:0] REG_TEMP    = 3'd0;
   localparam logic [2:0] REG_PRESS_A = 3'd1;
   localparam logic [2:0] REG_PRESS_B = 3'd2;
   localparam logic [2:0] REG_PRESS_C = 3'd3;
   localparam logic [2:0] REG_HUM_A   = 3'd4;
   localparam logic [2:0] REG_HUM_B   = 3'd5;

   typedef struct packed {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] fine_temp;
      logic [31:0]        pressure_q24_8;
      logic [28:0]        humidity_scaled;
      logic               pressure_updated;
   } rsp_type;

   // shared serial multiplier command and status
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] p;
   } mul_sts_type;

   typedef struct packed {
      logic        start;
      logic [63:0] n;
      logic [63:0] d;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } div_sts_type;

endpackage

// ===== sv/pth_sensor_compensation_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pth_sensor_compensation_unit
// integer pressure, temperature and humidity compensation, one request at
// a time, every product through one shared bit-serial multiplier
// ---------------------------------------------------------------------------
// sequence: 21 multiplies and one divide from acceptance to result valid;
//   skipped fields or a zero divisor shorten it
// a new request is taken only after the last one is done; the shared serial multiplier sets it
// reset: synchronous, clears control, calibration to 0, stored results to
//   the skip codes
module pth_sensor_compensation_unit
   import pthc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_WAIT = 5'b00100,
      ST_DIV = 5'b01000,
      ST_OUT = 5'b10000
   } state_type;

   logic [47:0] tc_ff, pa_ff, pb_ff, pc_ff;
   logic [31:0] ha_ff, hb_ff;
   logic [31:0] ft_ff, pr_ff, hu_ff;
   logic        upd_ff;
   req_type     rq_ff;
   state_type   st_ff, st_in;
   logic [5:0]  op_ff, op_in;
   logic [63:0] r_ff [0:7];
   logic [63:0] r_in [0:7];
   logic [63:0] res;
   logic        rsp_valid_ff;
   rsp_type     out_ff;

   mul_cmd_type mc;
   mul_sts_type ms;
   div_cmd_type dc;
   div_sts_type ds;

   pthc_mul u_mul (.clock(clock), .reset(reset), .cmd(mc), .sts(ms));
   pthc_div u_div (.clock(clock), .reset(reset), .cmd(dc), .sts(ds));

   function automatic logic [63:0] sx16(input logic [15:0] v);
      sx16 = {{48{v[15]}}, v};
   endfunction
   function automatic logic [31:0] s32(input logic [31:0] v, input int s);
      s32 = $unsigned($signed(v) >>> s);
   endfunction
   function automatic logic [63:0] s64(input logic [63:0] v, input int s);
      s64 = $unsigned($signed(v) >>> s);
   endfunction

   // calibration words
   logic [31:0] t, t1, t2, t3, h1, h2, h3, h4, h5, h6;
   logic [63:0] ip, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t  = {12'd0, rq_ff.raw_temperature[23:4]};
   assign t1 = {16'd0, tc_ff[15:0]};
   assign t2 = {{16{tc_ff[31]}}, tc_ff[31:16]};
   assign t3 = {{16{tc_ff[47]}}, tc_ff[47:32]};
   assign ip = {44'd0, rq_ff.raw_pressure[23:4]};
   assign p1 = {48'd0, pa_ff[15:0]};
   assign p2 = sx16(pa_ff[31:16]);
   assign p3 = sx16(pa_ff[47:32]);
   assign p4 = sx16(pb_ff[15:0]);
   assign p5 = sx16(pb_ff[31:16]);
   assign p6 = sx16(pb_ff[47:32]);
   assign p7 = sx16(pc_ff[15:0]);
   assign p8 = sx16(pc_ff[31:16]);
   assign p9 = sx16(pc_ff[47:32]);
   assign h1 = {24'd0, ha_ff[7:0]};
   assign h2 = {{16{ha_ff[23]}}, ha_ff[23:8]};
   assign h3 = {24'd0, ha_ff[31:24]};
   assign h4 = {{20{hb_ff[11]}}, hb_ff[11:0]};
   assign h5 = {{20{hb_ff[23]}}, hb_ff[23:12]};
   assign h6 = {{24{hb_ff[31]}}, hb_ff[31:24]};

   // operand selection per microcode step; r registers hold intermediates
   localparam logic [5:0] OP_T0 = 6'd0, OP_P0 = 6'd3, OP_H0 = 6'd15, OP_END = 6'd28;
   logic [63:0] oa, ob;
   logic        skip_t, skip_p, skip_h;
   assign skip_t = rq_ff.raw_temperature == SKIP_TP;
   assign skip_p = rq_ff.raw_pressure == SKIP_TP;
   assign skip_h = rq_ff.raw_humidity == SKIP_H;

   logic [63:0] fa;
   logic [31:0] hv;
   assign fa = {{32{ft_ff[31]}}, ft_ff} - 64'd128000;
   assign hv = ft_ff - 32'd76800;

   always_comb begin
      oa = '0;
      ob = '0;
      unique case (op_ff)
         6'd0: begin oa = {32'd0, (t >> 3) - (t1 << 1)}; ob = {32'd0, t2}; end
         6'd1: begin oa = {32'd0, (t >> 4) - t1}; ob = oa; end
         6'd2: begin oa = {32'd0, s32(r_ff[1][31:0], 12)}; ob = {32'd0, t3}; end
         6'd3: begin oa = fa; ob = fa; end
         6'd4: begin oa = r_ff[0]; ob = p6; end
         6'd5: begin oa = fa; ob = p5; end
         6'd6: begin oa = r_ff[0]; ob = p3; end
         6'd7: begin oa = fa; ob = p2; end
         6'd8: begin oa = (64'd1 << 47) + r_ff[3]; ob = p1; end
         6'd9: begin oa = ((64'd1048576 - ip) << 31) - r_ff[1]; ob = 64'd3125; end
         6'd10: begin oa = s64(r_ff[5], 13); ob = p9; end
         6'd11: begin oa = r_ff[6]; ob = s64(r_ff[5], 13); end
         6'd12: begin oa = p8; ob = r_ff[5]; end
         6'd15: begin oa = {32'd0, h5}; ob = {32'd0, hv}; end
         6'd16: begin oa = {32'd0, hv}; ob = {32'd0, h6}; end
         6'd17: begin oa = {32'd0, hv}; ob = {32'd0, h3}; end
         6'd18: begin oa = r_ff[1]; ob = r_ff[2]; end
         6'd19: begin oa = r_ff[3]; ob = {32'd0, h2}; end
         6'd20: begin oa = r_ff[0]; ob = r_ff[4]; end
         6'd21: begin oa = {32'd0, s32(r_ff[5][31:0], 15)}; ob = oa; end
         6'd22: begin oa = {32'd0, s32(r_ff[6][31:0], 7)}; ob = {32'd0, h1}; end
         default: begin oa = '0; ob = '0; end
      endcase
   end

   // post-processing of a finished product into the scratch registers
   logic [31:0] pl, hw, hx;
   always_comb begin
      for (int i = 0; i < 8; i++) r_in[i] = r_ff[i];
      pl = ms.p[31:0];
      hx = (({16'd0, rq_ff.raw_humidity} << 14) - (h4 << 20) - pl + 32'd16384);
      hw = s32(r_ff[3][31:0], 10) + 32'd2097152;
      res = ms.p;
      unique case (op_ff)
         6'd0: r_in[0] = {32'd0, s32(pl, 11)};
         6'd1: r_in[1] = {32'd0, pl};
         6'd2: r_in[2] = {32'd0, r_ff[0][31:0] + s32(pl, 14)};
         6'd3: r_in[0] = res;
         6'd4: r_in[1] = res + (p4 << 35);
         6'd5: r_in[1] = r_ff[1] + (res << 17);
         6'd6: r_in[3] = s64(res, 8);
         6'd7: r_in[3] = r_ff[3] + (res << 12);
         6'd8: r_in[4] = s64(res, 33);
         6'd9: r_in[5] = res;
         6'd10: r_in[6] = res;
         6'd11: r_in[6] = s64(res, 25);
         6'd12: r_in[7] = s64(res, 19);
         6'd15: r_in[0] = {32'd0, s32(hx, 15)};
         6'd16: r_in[1] = {32'd0, s32(pl, 10)};
         6'd17: r_in[2] = {32'd0, s32(pl, 11) + 32'd32768};
         6'd18: r_in[3] = {32'd0, pl};
         6'd19: r_in[4] = {32'd0, s32(pl + 32'd8192, 14)};
         6'd20: r_in[5] = {32'd0, pl};
         6'd21: r_in[6] = {32'd0, pl};
         6'd22: r_in[7] = {32'd0, r_ff[5][31:0] - s32(pl, 4)};
         default: r_in[0] = r_ff[0];
      endcase
      if (op_ff == 6'd18) r_in[3] = {32'd0, pl};
      if (op_ff == 6'd19) r_in[3] = {32'd0, hw};
   end

   // step 18 keeps y*z; step 19 multiplies (y*z>>10 + 2^21) by H2
   logic [63:0] ob19;
   assign ob19 = (op_ff == 6'd19) ? {32'd0, s32(r_ff[3][31:0], 10) + 32'd2097152} : oa;

   logic [5:0] nxt_op;
   always_comb begin
      nxt_op = op_ff + 6'd1;
      if (op_ff == 6'd2) nxt_op = OP_P0;
      if (op_ff == 6'd12) nxt_op = OP_H0;
      if (op_ff == 6'd22) nxt_op = OP_END;
   end

   logic [31:0] hfin;
   logic [63:0] pfin;
   assign hfin = r_ff[7][31] ? 32'd0 : ((r_ff[7][31:0] > HUM_MAX) ? HUM_MAX : r_ff[7][31:0]);
   assign pfin = s64(r_ff[5] + r_ff[6] + r_in[7], 8) + (p7 << 4);

   always_comb begin
      st_in = st_ff;
      op_in = op_ff;
      mc = '{start: 1'b0, a: (op_ff == 6'd19) ? ob19 : oa, b: ob};
      // the dividend is the product finishing in this cycle
      dc = '{start: 1'b0, n: ms.p, d: r_ff[4]};
      unique case (st_ff)
         ST_IDLE: if (req_valid) begin
            st_in = ST_ISSUE;
            op_in = OP_T0;
         end
         ST_ISSUE: begin
            priority if (op_ff == OP_T0 && skip_t) op_in = OP_P0;
            else if (op_ff == OP_P0 && skip_p) op_in = OP_H0;
            else if (op_ff == 6'd9 && r_ff[4] == 64'd0) op_in = OP_H0;
            else if (op_ff == OP_H0 && skip_h) op_in = OP_END;
            else if (op_ff == OP_END) st_in = ST_OUT;
            else begin
               mc.start = 1'b1;
               st_in = ST_WAIT;
            end
         end
         ST_WAIT: if (ms.done) begin
            if (op_ff == 6'd9) begin
               dc.start = 1'b1;
               st_in = ST_DIV;
            end else begin
               op_in = nxt_op;
               st_in = ST_ISSUE;
            end
         end
         ST_DIV: if (ds.done) begin
            op_in = 6'd10;
            st_in = ST_ISSUE;
         end
         ST_OUT: if (!rsp_valid_ff || !rsp_stall) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         op_ff <= '0;
         rsp_valid_ff <= 1'b0;
         tc_ff <= '0; pa_ff <= '0; pb_ff <= '0; pc_ff <= '0;
         ha_ff <= '0; hb_ff <= '0;
         ft_ff <= 32'h800000; pr_ff <= 32'h800000; hu_ff <= 32'h8000;
         upd_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         op_ff <= op_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_TEMP:    tc_ff <= csr_data;
               REG_PRESS_A: pa_ff <= csr_data;
               REG_PRESS_B: pb_ff <= csr_data;
               REG_PRESS_C: pc_ff <= csr_data;
               REG_HUM_A:   ha_ff <= csr_data[31:0];
               REG_HUM_B:   hb_ff <= csr_data[31:0];
               default: ;
            endcase
         end
         if (st_ff == ST_IDLE && req_valid) upd_ff <= 1'b0;
         if (st_ff == ST_WAIT && ms.done && op_ff == 6'd2) ft_ff <= r_in[2][31:0];
         if (st_ff == ST_WAIT && ms.done && op_ff == 6'd12) begin
            pr_ff  <= pfin[31:0];
            upd_ff <= 1'b1;
         end
         if (st_ff == ST_ISSUE && op_ff == OP_END && !skip_h) hu_ff <= hfin;
         if (st_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (st_ff == ST_IDLE && req_valid) rq_ff <= req_data;
      if (st_ff == ST_WAIT && ms.done) for (int i = 0; i < 8; i++) r_ff[i] <= r_in[i];
      if (st_ff == ST_DIV && ds.done) r_ff[5] <= ds.q;
      if (st_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         out_ff.fine_temp        <= $signed(ft_ff);
         out_ff.pressure_q24_8   <= pr_ff;
         out_ff.humidity_scaled  <= hu_ff[28:0];
         out_ff.pressure_updated <= upd_ff;
      end
   end

   assign req_stall = st_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_WAIT |-> req_stall) else $error("request taken while busy");
   a_hum_clamp: assert property (@(posedge clock) disable iff (reset)
      hu_ff <= 32'h8000 || hu_ff <= HUM_MAX) else $error("humidity out of range");
   a_div_ok: assert property (@(posedge clock) disable iff (reset)
      dc.start |-> r_ff[4] != 64'd0) else $error("divide by zero started");

endmodule

// ===== sv/pthc_mul.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pthc_mul
// bit-serial 64x64 multiplier, low 64 bits of product, one bit per cycle
// ---------------------------------------------------------------------------
module pthc_mul
   import pthc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_sts_type sts
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [63:0] mplier_ff, mplier_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         acc_in    = '0;
         mcand_in  = cmd.a;
         mplier_in = cmd.b;
         cnt_in    = 7'd0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = {mcand_ff[62:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[63:1]};
         cnt_in    = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign sts.done = done_ff;
   assign sts.p    = acc_ff;

endmodule

// ===== sv/pthc_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pthc_div
// signed 64-bit restoring divider truncating toward zero, one bit per cycle
// ---------------------------------------------------------------------------
module pthc_div
   import pthc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] na, nd;

   always_comb begin
      na = cmd.n[63] ? (64'd0 - cmd.n) : cmd.n;
      nd = cmd.d[63] ? (64'd0 - cmd.d) : cmd.d;
      trial = {rem_ff, quo_ff[63]} - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = '0;
         quo_in  = na;
         den_in  = nd;
         neg_in  = cmd.n[63] ^ cmd.d[63];
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign sts.done = done_ff;
   assign sts.q    = neg_ff ? (64'd0 - quo_ff) : quo_ff;

endmodule
